// ===== design/lpfs_pkg.sv =====
package lpfs_pkg;

  localparam int unsigned HDR_BYTES    = 12;
  localparam int unsigned STREAM_BYTES = 8;

  typedef logic [3:0] hdr_count_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [63:0] stream_number;
    logic [31:0] record_length;
    logic        last;
  } result_t;

  localparam hdr_count_t LAST_HDR_IDX    = hdr_count_t'(HDR_BYTES - 1);
  localparam hdr_count_t STREAM_HDR_BYTES = hdr_count_t'(STREAM_BYTES);

endpackage

// ===== design/lpfs_byte_if.sv =====
interface lpfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== design/lpfs_rec_if.sv =====
interface lpfs_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [63:0] stream_number;
  logic [31:0] record_length;
  logic        last;

  modport source (
    output valid, output kind, output data_byte, output stream_number,
    output record_length, output last, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input stream_number,
    input record_length, input last, output ready
  );
endinterface

// ===== design/length_prefixed_frame_splitter.sv =====
// length-prefixed record deframer
// in_ch: one raw byte per word; each record is an 8-byte big-endian stream
//   number, a 4-byte big-endian length, then that many payload bytes
// out_ch: exactly one result word per input word; kind tells header byte,
//   payload byte or empty record, with stream number and length attached
//   and last set on the final payload byte or on an empty record
// path: an accepted word is held in the input register, then the core
//   state update loads its result into the result register
// throughput: one word per cycle while out_ch.ready is high; the core
//   state update lies between the input register and the result register
// reset: rst clears the record state to the header phase with zeroed
//   stream number and length; both pipeline registers come up empty
// stall: while out_ch.ready is low the result holds, the input register
//   still fills, and in_ch.ready drops once both registers are occupied
module length_prefixed_frame_splitter (
  input logic           clk,
  input logic           rst,
  lpfs_byte_if.sink     in_ch,
  lpfs_rec_if.source    out_ch
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_valid;
  lpfs_pkg::result_t out_res;
  lpfs_pkg::result_t res;
  logic              load;

  assign load        = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte <= in_ch.in_byte;
    end
  end

  lpfs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (load),
    .in_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_res.kind;
  assign out_ch.data_byte     = out_res.data_byte;
  assign out_ch.stream_number = out_res.stream_number;
  assign out_ch.record_length = out_res.record_length;
  assign out_ch.last          = out_res.last;

  a_load_fills_result: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("result register not loaded");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !load) |=> (in_valid && $stable(in_byte)))
    else $error("pending input word lost");

  a_header_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.last && out_res.kind == lpfs_pkg::KIND_HEADER))
    else $error("last flagged on header word");

endmodule

// ===== design/lpfs_core.sv =====
module lpfs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  output lpfs_pkg::result_t res
);

  logic                  in_payload;
  logic                  in_payload_next;
  lpfs_pkg::hdr_count_t  header_count;
  lpfs_pkg::hdr_count_t  header_count_next;
  logic [63:0]           stream_reg;
  logic [63:0]           stream_reg_next;
  logic [31:0]           length_reg;
  logic [31:0]           length_reg_next;
  logic [31:0]           bytes_left;
  logic [31:0]           bytes_left_next;

  always_comb begin
    in_payload_next   = in_payload;
    header_count_next = header_count;
    stream_reg_next   = stream_reg;
    length_reg_next   = length_reg;
    bytes_left_next   = bytes_left;
    res.kind          = lpfs_pkg::KIND_HEADER;
    res.data_byte     = 8'd0;
    res.last          = 1'b0;
    if (in_payload) begin
      res.kind      = lpfs_pkg::KIND_PAYLOAD;
      res.data_byte = in_byte;
      if (bytes_left <= 32'd1) begin
        res.last          = 1'b1;
        bytes_left_next   = 32'd0;
        in_payload_next   = 1'b0;
        header_count_next = '0;
      end else begin
        bytes_left_next = bytes_left - 32'd1;
      end
    end else begin
      if (header_count < lpfs_pkg::STREAM_HDR_BYTES) begin
        stream_reg_next = {stream_reg[55:0], in_byte};
      end else begin
        length_reg_next = {length_reg[23:0], in_byte};
      end
      if (header_count >= lpfs_pkg::LAST_HDR_IDX) begin
        header_count_next = '0;
        if (length_reg_next == 32'd0) begin
          res.kind = lpfs_pkg::KIND_EMPTY;
          res.last = 1'b1;
        end else begin
          in_payload_next = 1'b1;
          bytes_left_next = length_reg_next;
        end
      end else begin
        header_count_next = header_count + 4'd1;
      end
    end
    res.stream_number = stream_reg_next;
    res.record_length = length_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      header_count <= '0;
      stream_reg   <= '0;
      length_reg   <= '0;
      bytes_left   <= '0;
    end else if (step) begin
      in_payload   <= in_payload_next;
      header_count <= header_count_next;
      stream_reg   <= stream_reg_next;
      length_reg   <= length_reg_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // header count only runs in the header phase
  a_count_idle_in_payload: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> header_count == '0)
    else $error("header count nonzero during payload");

  // payload phase never starts with nothing to send
  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (step && !in_payload && in_payload_next) |=> bytes_left != 32'd0)
    else $error("payload entered with zero length");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.kind == lpfs_pkg::KIND_EMPTY) |-> (res.last && length_reg_next == 32'd0))
    else $error("empty record result malformed");

endmodule

// ===== bench/tb_length_prefixed_frame_splitter.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_frame_splitter;

  logic clk = 1'b0;
  logic rst;

  lpfs_byte_if in_ch ();
  lpfs_rec_if  out_ch ();

  length_prefixed_frame_splitter u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // deframer state as seen by the predictor
  logic                 pred_in_payload;
  lpfs_pkg::hdr_count_t pred_hdr_cnt;
  logic [63:0]          pred_stream;
  logic [31:0]          pred_length;
  logic [31:0]          pred_remaining;

  lpfs_pkg::result_t deframed_q[$];

  int src_idle_pct;
  int snk_idle_pct;
  int error_count;
  int words_sent;
  int records_sent;
  int results_checked;
  int payload_seen;
  int empty_seen;

  function automatic lpfs_pkg::result_t deframe_byte(input logic [7:0] b);
    lpfs_pkg::result_t r;
    r = '0;
    r.kind = lpfs_pkg::KIND_HEADER;
    if (pred_in_payload) begin
      r.kind = lpfs_pkg::KIND_PAYLOAD;
      r.data_byte = b;
      if (pred_remaining <= 32'd1) begin
        r.last = 1'b1;
        pred_remaining = '0;
        pred_in_payload = 1'b0;
        pred_hdr_cnt = '0;
      end else begin
        pred_remaining = pred_remaining - 32'd1;
      end
    end else begin
      if (pred_hdr_cnt < lpfs_pkg::STREAM_HDR_BYTES) begin
        pred_stream = {pred_stream[55:0], b};
      end else begin
        pred_length = {pred_length[23:0], b};
      end
      if (pred_hdr_cnt >= lpfs_pkg::LAST_HDR_IDX) begin
        pred_hdr_cnt = '0;
        if (pred_length == 32'd0) begin
          r.kind = lpfs_pkg::KIND_EMPTY;
          r.last = 1'b1;
        end else begin
          pred_in_payload = 1'b1;
          pred_remaining = pred_length;
        end
      end else begin
        pred_hdr_cnt = pred_hdr_cnt + lpfs_pkg::hdr_count_t'(1);
      end
    end
    r.stream_number = pred_stream;
    r.record_length = pred_length;
    return r;
  endfunction

  task automatic report_error(input string what, input lpfs_pkg::result_t want,
                              input lpfs_pkg::result_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t %s: exp kind=%0d data=%h stream=%h len=%h last=%b", $realtime, what,
               want.kind, want.data_byte, want.stream_number, want.record_length, want.last);
      $display("%0t %s: got kind=%0d data=%h stream=%h len=%h last=%b", $realtime, what,
               got.kind, got.data_byte, got.stream_number, got.record_length, got.last);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    lpfs_pkg::result_t got;
    lpfs_pkg::result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind          = lpfs_pkg::kind_t'(out_ch.kind);
      got.data_byte     = out_ch.data_byte;
      got.stream_number = out_ch.stream_number;
      got.record_length = out_ch.record_length;
      got.last          = out_ch.last;
      if (deframed_q.size() == 0) begin
        want = '0;
        report_error("unexpected word", want, got);
      end else begin
        want = deframed_q.pop_front();
        results_checked++;
        if (want.kind == lpfs_pkg::KIND_PAYLOAD) payload_seen++;
        if (want.kind == lpfs_pkg::KIND_EMPTY) empty_seen++;
        if (got !== want) report_error("mismatch", want, got);
      end
    end
  end

  // receiver back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    #200000;
    $display("timeout with %0d words outstanding", deframed_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    deframed_q.push_back(deframe_byte(b));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [63:0] stream, input logic [31:0] len);
    for (int i = 7; i >= 0; i--) send_byte(stream[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(len[i*8 +: 8]);
    records_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (deframed_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_empty_record();
    send_header(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
  endtask

  task automatic test_single_byte_record();
    send_header(64'd0, 32'd1);
    send_byte(8'hFF);
  endtask

  task automatic test_random_records(input int src_pct, input int snk_pct, input int nwords);
    int start;
    int pick;
    logic [63:0] stream;
    logic [31:0] len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = words_sent;
    while (words_sent - start < nwords) begin
      pick = $urandom_range(99);
      if (pick < 10) stream = '1;
      else if (pick < 20) stream = '0;
      else stream = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 15) len = 32'd0;
      else if (pick < 85) len = $urandom_range(16, 1);
      else if (pick < 97) len = $urandom_range(64, 17);
      else len = $urandom_range(300, 65);
      send_header(stream, len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
    end
  endtask

  // stream ends inside a record that can never complete
  task automatic test_truncated_record();
    send_header({$urandom, $urandom}, 32'hFFFF_FFFF);
    repeat (20) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    error_count     = 0;
    words_sent      = 0;
    records_sent    = 0;
    results_checked = 0;
    payload_seen    = 0;
    empty_seen      = 0;
    pred_in_payload = 1'b0;
    pred_hdr_cnt    = '0;
    pred_stream     = '0;
    pred_length     = '0;
    pred_remaining  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_record();
    test_single_byte_record();
    wait_idle();
    test_random_records(27, 66, 340);
    wait_idle();
    test_random_records(66, 27, 340);
    wait_idle();
    test_random_records(0, 0, 340);
    test_truncated_record();
    wait_idle();

    $display("sent %0d words in %0d records, %0d payload and %0d empty-record results",
             words_sent, records_sent, payload_seen, empty_seen);
    $display("checked %0d result words, %0d errors", results_checked, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
